// ----- rtl/mbo_pkg.sv -----
// Shared types and constants for the market-by-order book.
package mbo_pkg;

	localparam logic [2:0] KIND_IGNORE = 3'd0;
	localparam logic [2:0] KIND_ADD    = 3'd1;
	localparam logic [2:0] KIND_CANCEL = 3'd2;
	localparam logic [2:0] KIND_MODIFY = 3'd3;
	localparam logic [2:0] KIND_CLEAR  = 3'd4;

	localparam logic [2:0] ERR_OK        = 3'd0;
	localparam logic [2:0] ERR_BAD_SIDE  = 3'd1;
	localparam logic [2:0] ERR_NO_LEVEL  = 3'd2;
	localparam logic [2:0] ERR_NO_ORDER  = 3'd3;
	localparam logic [2:0] ERR_DUP_ID    = 3'd4;
	localparam logic [2:0] ERR_OVERCXL   = 3'd5;
	localparam logic [2:0] ERR_SIDE_CHG  = 3'd6;
	localparam logic [2:0] ERR_FULL      = 3'd7;

	localparam logic signed [63:0] PX_UNDEF = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic [8:0]         COUNT_SAT = 9'd511;

	typedef struct packed {
		logic [2:0]         kind;
		logic [1:0]         side;
		logic [63:0]        ord_key;
		logic signed [63:0] price;
		logic [31:0]        quantity;
		logic               top_of_book;
		logic [3:0]         level_index;
	} item_t;

	typedef struct packed {
		logic signed [63:0] bid_price;
		logic [39:0]        bid_size;
		logic [8:0]         bid_count;
		logic signed [63:0] ask_price;
		logic [39:0]        ask_size;
		logic [8:0]         ask_count;
		logic signed [63:0] depth_price;
		logic [39:0]        depth_size;
		logic [8:0]         depth_count;
		logic [2:0]         error_code;
	} result_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_ADD,
		OP_CANCEL,
		OP_MODIFY,
		OP_CLEAR,
		OP_BADSIDE
	} op_t;

	typedef struct packed {
		op_t   op;
		item_t item;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OPSCAN,
		ST_APPLY,
		ST_CLR,
		ST_PUT,
		ST_BEST,
		ST_SEL,
		ST_NEXT,
		ST_RANK,
		ST_RSTEP,
		ST_SUM,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/mbo_front.sv -----
// Front end: accepts messages, classifies them and queues them for the engine.
module mbo_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  mbo_pkg::item_t item,
	output logic           cmd_valid,
	output mbo_pkg::cmd_t  cmd,
	input  logic           pop
);

	mbo_pkg::cmd_t slot_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	mbo_pkg::op_t  op;
	logic          push;

	always_comb begin
		op = mbo_pkg::OP_NOP;
		unique case (item.kind)
			mbo_pkg::KIND_ADD:    op = item.side[1] ? mbo_pkg::OP_BADSIDE : mbo_pkg::OP_ADD;
			mbo_pkg::KIND_CANCEL: op = item.side[1] ? mbo_pkg::OP_BADSIDE : mbo_pkg::OP_CANCEL;
			mbo_pkg::KIND_MODIFY: op = item.side[1] ? mbo_pkg::OP_BADSIDE : mbo_pkg::OP_MODIFY;
			mbo_pkg::KIND_CLEAR:  op = mbo_pkg::OP_CLEAR;
			default:              op = mbo_pkg::OP_NOP;
		endcase
	end

	assign busy      = (cnt_q == 2'd2);
	assign push      = start && !busy;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= '{op: op, item: item};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- rtl/mbo_engine.sv -----
// Back end: applies one queued transaction to the order store, then ranks levels.
module mbo_engine #(
	parameter int MAX_ORDERS = 256,
	parameter int MAX_DEPTH  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  mbo_pkg::cmd_t    cmd,
	output logic             pop,
	output logic             done,
	output mbo_pkg::result_t result
);

	localparam int AW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
	localparam logic [AW:0]   N_ORD     = (AW + 1)'(MAX_ORDERS);
	localparam logic [AW-1:0] LAST_IDX  = AW'(MAX_ORDERS - 1);
	localparam logic [8:0]    DEPTH_LIM = 9'(MAX_DEPTH);

	typedef struct packed {
		logic [63:0]        id;
		logic signed [63:0] price;
		logic [31:0]        size;
		logic               side;
		logic               tob;
	} entry_t;

	entry_t mem [MAX_ORDERS];

	mbo_pkg::state_t  st_q, st_d;
	mbo_pkg::cmd_t    cmd_q;
	mbo_pkg::item_t   it;
	logic [MAX_ORDERS-1:0] valid_q;

	logic [AW:0]   cnt_q;
	logic          pv_s1;
	logic [AW-1:0] pidx_s1;
	entry_t        rd_s1;

	logic          known_q, free_q, room_q, level_q, hit_q;
	logic [AW-1:0] known_idx_q, free_idx_q, hit_idx_q;
	entry_t        known_e_q, hit_e_q;
	logic [2:0]    err_q;

	logic               bid_found_q, ask_found_q, dep_en_q, dep_found_q, rk_found_q;
	logic signed [63:0] bid_px_q, ask_px_q, dep_px_q, rk_px_q;
	logic [3:0]         dep_d_q;
	logic [39:0]        bid_sz_q, ask_sz_q, dep_sz_q;
	logic [8:0]         bid_ct_q, ask_ct_q, dep_ct_q;

	mbo_pkg::result_t res_q;
	logic             done_q;

	// entry under inspection this cycle
	entry_t e;
	logic   v, sd0, m_side, m_px, last, scan, issue, px_undef;

	// apply decision
	logic [2:0]    dec_err;
	logic          dec_wr, dec_kill, dec_clr, dec_put, dec_wipe;
	logic [AW-1:0] dec_waddr;
	entry_t        dec_wdata;

	logic          mem_we;
	logic [AW-1:0] waddr;
	entry_t        wdata;

	function automatic logic [39:0] sat_add(input logic [39:0] a, input logic [31:0] b);
		logic [40:0] s;
		s = {1'b0, a} + 41'(b);
		return s[40] ? '1 : s[39:0];
	endfunction

	function automatic logic [8:0] cnt_inc(input logic [8:0] c, input logic tob);
		return (tob || c == mbo_pkg::COUNT_SAT) ? c : c + 9'd1;
	endfunction

	assign it       = cmd_q.item;
	assign e        = rd_s1;
	assign v        = valid_q[pidx_s1];
	assign sd0      = it.side[0];
	assign m_side   = (e.side == sd0);
	assign m_px     = (e.price == it.price);
	assign px_undef = (it.price == mbo_pkg::PX_UNDEF);
	assign last     = pv_s1 && (pidx_s1 == LAST_IDX);
	assign issue    = scan && !last && (cnt_q < N_ORD);

	always_comb begin
		dec_err   = mbo_pkg::ERR_OK;
		dec_wr    = 1'b0;
		dec_kill  = 1'b0;
		dec_clr   = 1'b0;
		dec_put   = 1'b0;
		dec_wipe  = 1'b0;
		dec_waddr = hit_idx_q;
		dec_wdata = hit_e_q;
		unique case (cmd_q.op)
			mbo_pkg::OP_BADSIDE: dec_err = mbo_pkg::ERR_BAD_SIDE;
			mbo_pkg::OP_CLEAR:   dec_wipe = 1'b1;
			mbo_pkg::OP_CANCEL: begin
				if (!level_q) begin
					dec_err = mbo_pkg::ERR_NO_LEVEL;
				end else if (!hit_q) begin
					dec_err = mbo_pkg::ERR_NO_ORDER;
				end else if (hit_e_q.size < it.quantity) begin
					dec_err = mbo_pkg::ERR_OVERCXL;
				end else if (hit_e_q.size == it.quantity) begin
					dec_kill = 1'b1;
				end else begin
					dec_wr         = 1'b1;
					dec_wdata.size = hit_e_q.size - it.quantity;
				end
			end
			mbo_pkg::OP_ADD, mbo_pkg::OP_MODIFY: begin
				if (cmd_q.op == mbo_pkg::OP_MODIFY && known_q) begin
					if (known_e_q.side != sd0) begin
						dec_err = mbo_pkg::ERR_SIDE_CHG;
					end else begin
						dec_wr          = 1'b1;
						dec_waddr       = known_idx_q;
						dec_wdata       = known_e_q;
						dec_wdata.price = it.price;
						dec_wdata.size  = it.quantity;
					end
				end else if (it.top_of_book) begin
					if (!px_undef && !room_q) begin
						dec_err = mbo_pkg::ERR_FULL;
					end else begin
						dec_clr = 1'b1;
					end
				end else if (known_q) begin
					dec_err = mbo_pkg::ERR_DUP_ID;
				end else if (!free_q) begin
					dec_err = mbo_pkg::ERR_FULL;
				end else begin
					dec_put = 1'b1;
				end
			end
			default: dec_err = mbo_pkg::ERR_OK;
		endcase
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			mbo_pkg::ST_IDLE:   if (cmd_valid) st_d = mbo_pkg::ST_OPSCAN;
			mbo_pkg::ST_OPSCAN: if (last) st_d = mbo_pkg::ST_APPLY;
			mbo_pkg::ST_APPLY: begin
				if (dec_clr) begin
					st_d = mbo_pkg::ST_CLR;
				end else if (dec_put) begin
					st_d = mbo_pkg::ST_PUT;
				end else begin
					st_d = mbo_pkg::ST_BEST;
				end
			end
			mbo_pkg::ST_CLR: begin
				if (last) st_d = px_undef ? mbo_pkg::ST_BEST : mbo_pkg::ST_PUT;
			end
			mbo_pkg::ST_PUT:    st_d = mbo_pkg::ST_BEST;
			mbo_pkg::ST_BEST:   if (last) st_d = mbo_pkg::ST_SEL;
			mbo_pkg::ST_SEL:    st_d = mbo_pkg::ST_NEXT;
			mbo_pkg::ST_NEXT: begin
				if (dep_found_q && dep_d_q != it.level_index) begin
					st_d = mbo_pkg::ST_RANK;
				end else begin
					st_d = mbo_pkg::ST_SUM;
				end
			end
			mbo_pkg::ST_RANK:   if (last) st_d = mbo_pkg::ST_RSTEP;
			mbo_pkg::ST_RSTEP:  st_d = mbo_pkg::ST_NEXT;
			mbo_pkg::ST_SUM:    if (last) st_d = mbo_pkg::ST_DONE;
			mbo_pkg::ST_DONE:   st_d = mbo_pkg::ST_IDLE;
			default:            st_d = mbo_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop    = (st_q == mbo_pkg::ST_IDLE) && cmd_valid;
		scan   = (st_q == mbo_pkg::ST_OPSCAN) || (st_q == mbo_pkg::ST_CLR) ||
			(st_q == mbo_pkg::ST_BEST) || (st_q == mbo_pkg::ST_RANK) ||
			(st_q == mbo_pkg::ST_SUM);
		mem_we = 1'b0;
		waddr  = dec_waddr;
		wdata  = dec_wdata;
		if (st_q == mbo_pkg::ST_APPLY) begin
			mem_we = dec_wr;
		end else if (st_q == mbo_pkg::ST_PUT) begin
			mem_we = 1'b1;
			waddr  = free_idx_q;
			wdata  = '{id: it.ord_key, price: it.price, size: it.quantity,
				side: sd0, tob: it.top_of_book};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (issue) begin
			rd_s1 <= mem[cnt_q[AW-1:0]];
		end
		if (pop) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= mbo_pkg::ST_IDLE;
			valid_q     <= '0;
			cnt_q       <= '0;
			pv_s1       <= 1'b0;
			pidx_s1     <= '0;
			done_q      <= 1'b0;
			known_q     <= 1'b0;
			free_q      <= 1'b0;
			room_q      <= 1'b0;
			level_q     <= 1'b0;
			hit_q       <= 1'b0;
			bid_found_q <= 1'b0;
			ask_found_q <= 1'b0;
			dep_en_q    <= 1'b0;
			dep_found_q <= 1'b0;
			rk_found_q  <= 1'b0;
			dep_d_q     <= 4'd0;
			err_q       <= mbo_pkg::ERR_OK;
		end else begin
			st_q   <= st_d;
			done_q <= 1'b0;
			if (issue) begin
				pv_s1   <= 1'b1;
				pidx_s1 <= cnt_q[AW-1:0];
				cnt_q   <= cnt_q + {{AW{1'b0}}, 1'b1};
			end else begin
				pv_s1 <= 1'b0;
				if (!scan || last) begin
					cnt_q <= '0;
				end
			end

			unique case (st_q)
				mbo_pkg::ST_IDLE: begin
					known_q     <= 1'b0;
					free_q      <= 1'b0;
					room_q      <= 1'b0;
					level_q     <= 1'b0;
					hit_q       <= 1'b0;
					bid_found_q <= 1'b0;
					ask_found_q <= 1'b0;
				end
				mbo_pkg::ST_OPSCAN: begin
					if (pv_s1) begin
						if (!v && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= pidx_s1;
						end
						if (!v || m_side) begin
							room_q <= 1'b1;
						end
						if (v && !e.tob && e.id == it.ord_key && !known_q) begin
							known_q     <= 1'b1;
							known_idx_q <= pidx_s1;
							known_e_q   <= e;
						end
						if (v && m_side && m_px) begin
							level_q <= 1'b1;
							// a top-of-book entry wins over a plain one
							if (e.id == it.ord_key && (!hit_q || e.tob)) begin
								hit_q     <= 1'b1;
								hit_idx_q <= pidx_s1;
								hit_e_q   <= e;
							end
						end
					end
				end
				mbo_pkg::ST_APPLY: begin
					err_q <= dec_err;
					if (dec_wipe) begin
						valid_q <= '0;
					end
					if (dec_kill) begin
						valid_q[hit_idx_q] <= 1'b0;
					end
					if (dec_clr) begin
						free_q <= 1'b0;
					end
				end
				mbo_pkg::ST_CLR: begin
					if (pv_s1) begin
						if (v && m_side) begin
							valid_q[pidx_s1] <= 1'b0;
						end
						if ((!v || m_side) && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= pidx_s1;
						end
					end
				end
				mbo_pkg::ST_PUT: valid_q[free_idx_q] <= 1'b1;
				mbo_pkg::ST_BEST: begin
					if (pv_s1 && v) begin
						if (!e.side) begin
							if (!bid_found_q || e.price > bid_px_q) begin
								bid_found_q <= 1'b1;
								bid_px_q    <= e.price;
							end
						end else if (!ask_found_q || e.price < ask_px_q) begin
							ask_found_q <= 1'b1;
							ask_px_q    <= e.price;
						end
					end
				end
				mbo_pkg::ST_SEL: begin
					dep_en_q    <= !it.side[1] && ({5'd0, it.level_index} < DEPTH_LIM);
					dep_found_q <= !it.side[1] && ({5'd0, it.level_index} < DEPTH_LIM) &&
						(sd0 ? ask_found_q : bid_found_q);
					dep_px_q    <= sd0 ? ask_px_q : bid_px_q;
					dep_d_q     <= 4'd0;
				end
				mbo_pkg::ST_NEXT: begin
					rk_found_q <= 1'b0;
					bid_sz_q   <= '0;
					ask_sz_q   <= '0;
					dep_sz_q   <= '0;
					bid_ct_q   <= '0;
					ask_ct_q   <= '0;
					dep_ct_q   <= '0;
				end
				mbo_pkg::ST_RANK: begin
					// next distinct price strictly behind the current level
					if (pv_s1 && v && m_side && (sd0 ? e.price > dep_px_q : e.price < dep_px_q)) begin
						if (!rk_found_q || (sd0 ? e.price < rk_px_q : e.price > rk_px_q)) begin
							rk_found_q <= 1'b1;
							rk_px_q    <= e.price;
						end
					end
				end
				mbo_pkg::ST_RSTEP: begin
					dep_found_q <= rk_found_q;
					dep_px_q    <= rk_px_q;
					dep_d_q     <= dep_d_q + 4'd1;
				end
				mbo_pkg::ST_SUM: begin
					if (pv_s1 && v) begin
						if (!e.side && bid_found_q && e.price == bid_px_q) begin
							bid_sz_q <= sat_add(bid_sz_q, e.size);
							bid_ct_q <= cnt_inc(bid_ct_q, e.tob);
						end
						if (e.side && ask_found_q && e.price == ask_px_q) begin
							ask_sz_q <= sat_add(ask_sz_q, e.size);
							ask_ct_q <= cnt_inc(ask_ct_q, e.tob);
						end
						if (m_side && dep_found_q && e.price == dep_px_q) begin
							dep_sz_q <= sat_add(dep_sz_q, e.size);
							dep_ct_q <= cnt_inc(dep_ct_q, e.tob);
						end
					end
				end
				mbo_pkg::ST_DONE: done_q <= 1'b1;
				default: done_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == mbo_pkg::ST_DONE) begin
			res_q.bid_price   <= bid_found_q ? bid_px_q : mbo_pkg::PX_UNDEF;
			res_q.bid_size    <= bid_sz_q;
			res_q.bid_count   <= bid_ct_q;
			res_q.ask_price   <= ask_found_q ? ask_px_q : mbo_pkg::PX_UNDEF;
			res_q.ask_size    <= ask_sz_q;
			res_q.ask_count   <= ask_ct_q;
			res_q.depth_price <= dep_found_q ? dep_px_q : mbo_pkg::PX_UNDEF;
			res_q.depth_size  <= dep_sz_q;
			res_q.depth_count <= dep_ct_q;
			res_q.error_code  <= err_q;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held for two cycles");
	a_put_free: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == mbo_pkg::ST_PUT) |-> !valid_q[free_idx_q])
		else $error("new order placed over a live entry");
	a_depth_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == mbo_pkg::ST_RANK) |-> dep_en_q)
		else $error("depth ranking ran for an absent request");

endmodule

// ----- rtl/market_by_order_book.sv -----
// Top level of the market-by-order book: front queue and book engine.
//
//  channel   | signals                  | direction | transfer
//  ----------+--------------------------+-----------+-------------------------
//  message   | start, busy, item        | in        | start && !busy
//  result    | done, result             | out       | done, one cycle, no stall
//
// With an idle engine each message costs an operation sweep, a best-price sweep, one
// ranking sweep per level ranked past the best on the message's side and a summing
// sweep; every pass sweeps the order store through its single read port,
// one entry per cycle. A top-of-book add adds one sweep, and resting a new order adds
// a put step. The front queue holds two messages, so busy rises only when both wait.
// Reset is asynchronous; the store needs no clearing sweep.
module market_by_order_book #(
	parameter int MAX_ORDERS = 256,
	parameter int MAX_DEPTH  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  mbo_pkg::item_t   item,
	output logic             done,
	output mbo_pkg::result_t result
);

	logic          cmd_valid;
	logic          pop;
	mbo_pkg::cmd_t cmd;

	mbo_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.pop       (pop)
	);

	mbo_engine #(
		.MAX_ORDERS (MAX_ORDERS),
		.MAX_DEPTH  (MAX_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.pop       (pop),
		.done      (done),
		.result    (result)
	);

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the market-by-order book: directed and random messages.
`timescale 1ns / 100ps

class book_scoreboard;
	localparam int N_ORD = 256;
	localparam int N_DEPTH = 16;

	bit              ent_valid [N_ORD];
	logic [63:0]     ent_id [N_ORD];
	logic signed [63:0] ent_px [N_ORD];
	logic [31:0]     ent_qty [N_ORD];
	bit              ent_side [N_ORD];
	bit              ent_tob [N_ORD];
	mbo_pkg::result_t pending_books[$];
	int              errors;

	function void clear_book();
		foreach (ent_valid[i]) ent_valid[i] = 0;
		pending_books.delete();
		errors = 0;
	endfunction

	function int find_known(logic [63:0] id);
		for (int i = 0; i < N_ORD; i++)
			if (ent_valid[i] && !ent_tob[i] && ent_id[i] == id) return i;
		return -1;
	endfunction

	function int find_free();
		for (int i = 0; i < N_ORD; i++)
			if (!ent_valid[i]) return i;
		return -1;
	endfunction

	function void rest(int i, logic [63:0] id, logic signed [63:0] px, logic [31:0] q,
			bit sd, bit tob);
		ent_valid[i] = 1;
		ent_id[i] = id;
		ent_px[i] = px;
		ent_qty[i] = q;
		ent_side[i] = sd;
		ent_tob[i] = tob;
	endfunction

	function logic [2:0] apply_add(bit sd, logic [63:0] id, logic signed [63:0] px,
			logic [31:0] q, bit tob);
		int room;
		int slot;
		if (tob) begin
			room = 0;
			for (int i = 0; i < N_ORD; i++)
				if (!ent_valid[i] || ent_side[i] == sd) room++;
			if (px != mbo_pkg::PX_UNDEF && room == 0) return mbo_pkg::ERR_FULL;
			for (int i = 0; i < N_ORD; i++)
				if (ent_valid[i] && ent_side[i] == sd) ent_valid[i] = 0;
			if (px != mbo_pkg::PX_UNDEF) rest(find_free(), id, px, q, sd, 1);
			return mbo_pkg::ERR_OK;
		end
		if (find_known(id) >= 0) return mbo_pkg::ERR_DUP_ID;
		slot = find_free();
		if (slot < 0) return mbo_pkg::ERR_FULL;
		rest(slot, id, px, q, sd, 0);
		return mbo_pkg::ERR_OK;
	endfunction

	function logic [2:0] apply_cancel(bit sd, logic [63:0] id, logic signed [63:0] px,
			logic [31:0] q);
		int hit;
		bit lvl;
		hit = -1;
		lvl = 0;
		for (int i = 0; i < N_ORD; i++) begin
			if (!ent_valid[i] || ent_side[i] != sd || ent_px[i] != px) continue;
			lvl = 1;
			if (ent_id[i] == id && (hit < 0 || ent_tob[i])) hit = i;
		end
		if (!lvl) return mbo_pkg::ERR_NO_LEVEL;
		if (hit < 0) return mbo_pkg::ERR_NO_ORDER;
		if (ent_qty[hit] < q) return mbo_pkg::ERR_OVERCXL;
		ent_qty[hit] -= q;
		if (ent_qty[hit] == 0) ent_valid[hit] = 0;
		return mbo_pkg::ERR_OK;
	endfunction

	// price level at the given depth on one side; absent gives undefined price
	function void level_at(logic [1:0] sd, int depth, output logic signed [63:0] px,
			output logic [39:0] sz, output logic [8:0] cnt);
		bit have_prev;
		bit found;
		logic signed [63:0] prev, best, p;
		logic [40:0] acc;
		px = mbo_pkg::PX_UNDEF;
		sz = 0;
		cnt = 0;
		have_prev = 0;
		prev = 0;
		acc = 0;
		if (sd > 1 || depth >= N_DEPTH) return;
		for (int d = 0; d <= depth; d++) begin
			found = 0;
			best = 0;
			for (int i = 0; i < N_ORD; i++) begin
				if (!ent_valid[i] || ent_side[i] != sd[0]) continue;
				p = ent_px[i];
				if (have_prev && (sd == 0 ? p >= prev : p <= prev)) continue;
				if (!found || (sd == 0 ? p > best : p < best)) begin
					best = p;
					found = 1;
				end
			end
			if (!found) return;
			prev = best;
			have_prev = 1;
		end
		for (int i = 0; i < N_ORD; i++) begin
			if (!ent_valid[i] || ent_side[i] != sd[0] || ent_px[i] != prev) continue;
			acc += ent_qty[i];
			if (acc > 41'hFF_FFFF_FFFF) acc = 41'hFF_FFFF_FFFF;
			if (!ent_tob[i] && cnt < mbo_pkg::COUNT_SAT) cnt++;
		end
		px = prev;
		sz = acc[39:0];
	endfunction

	function void note_message(mbo_pkg::item_t it);
		mbo_pkg::result_t r;
		logic [2:0] err;
		int k;
		err = mbo_pkg::ERR_OK;
		if (it.kind >= mbo_pkg::KIND_ADD && it.kind <= mbo_pkg::KIND_MODIFY && it.side > 1)
			err = mbo_pkg::ERR_BAD_SIDE;
		else if (it.kind == mbo_pkg::KIND_ADD)
			err = apply_add(it.side[0], it.ord_key, it.price, it.quantity, it.top_of_book);
		else if (it.kind == mbo_pkg::KIND_CANCEL)
			err = apply_cancel(it.side[0], it.ord_key, it.price, it.quantity);
		else if (it.kind == mbo_pkg::KIND_MODIFY) begin
			k = find_known(it.ord_key);
			if (k < 0)
				err = apply_add(it.side[0], it.ord_key, it.price, it.quantity,
					it.top_of_book);
			else if (ent_side[k] != it.side[0])
				err = mbo_pkg::ERR_SIDE_CHG;
			else begin
				ent_px[k] = it.price;
				ent_qty[k] = it.quantity;
			end
		end else if (it.kind == mbo_pkg::KIND_CLEAR)
			foreach (ent_valid[i]) ent_valid[i] = 0;
		level_at(2'd0, 0, r.bid_price, r.bid_size, r.bid_count);
		level_at(2'd1, 0, r.ask_price, r.ask_size, r.ask_count);
		level_at(it.side, it.level_index, r.depth_price, r.depth_size, r.depth_count);
		r.error_code = err;
		pending_books.push_back(r);
	endfunction

	function void check_book(mbo_pkg::result_t got);
		mbo_pkg::result_t exp;
		if (pending_books.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		exp = pending_books.pop_front();
		if (got.bid_price !== exp.bid_price || got.bid_size !== exp.bid_size ||
				got.bid_count !== exp.bid_count) begin
			$display("%0t: best bid expected %0d/%0d/%0d actual %0d/%0d/%0d", $time,
				exp.bid_price, exp.bid_size, exp.bid_count,
				got.bid_price, got.bid_size, got.bid_count);
			errors++;
		end
		if (got.ask_price !== exp.ask_price || got.ask_size !== exp.ask_size ||
				got.ask_count !== exp.ask_count) begin
			$display("%0t: best ask expected %0d/%0d/%0d actual %0d/%0d/%0d", $time,
				exp.ask_price, exp.ask_size, exp.ask_count,
				got.ask_price, got.ask_size, got.ask_count);
			errors++;
		end
		if (got.depth_price !== exp.depth_price || got.depth_size !== exp.depth_size ||
				got.depth_count !== exp.depth_count) begin
			$display("%0t: depth level expected %0d/%0d/%0d actual %0d/%0d/%0d", $time,
				exp.depth_price, exp.depth_size, exp.depth_count,
				got.depth_price, got.depth_size, got.depth_count);
			errors++;
		end
		if (got.error_code !== exp.error_code) begin
			$display("%0t: error_code expected %0d actual %0d", $time,
				exp.error_code, got.error_code);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam int CYCLE_LIMIT = 6_000_000;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	mbo_pkg::item_t   item;
	logic             done;
	mbo_pkg::result_t result;

	book_scoreboard   book;
	int               cycles;
	bit               no_gaps;
	logic [63:0]      live_ids[$];

	market_by_order_book dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done) book.check_book(result);
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one message transaction; start is held until accepted, the caller drops it
	task automatic send_message(mbo_pkg::item_t it);
		int gap;
		if (!no_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		book.note_message(it);
		@(negedge clk);
	endtask

	function automatic mbo_pkg::item_t make_msg(logic [2:0] kind, logic [1:0] sd,
			logic [63:0] id, logic signed [63:0] px, logic [31:0] q, bit tob,
			logic [3:0] lvl);
		mbo_pkg::item_t it;
		it.kind = kind;
		it.side = sd;
		it.ord_key = id;
		it.price = px;
		it.quantity = q;
		it.top_of_book = tob;
		it.level_index = lvl;
		return it;
	endfunction

	// mostly well-formed traffic over a small id and price pool so levels collide
	function automatic mbo_pkg::item_t random_msg();
		mbo_pkg::item_t it;
		int pick;
		it.ord_key = live_ids.size() > 0 && $urandom_range(0, 2) != 0 ?
			live_ids[$urandom_range(0, live_ids.size() - 1)] : 64'($urandom_range(1, 60));
		it.side = $urandom_range(0, 19) == 0 ? 2'($urandom_range(2, 3)) :
			2'($urandom_range(0, 1));
		it.price = 64'sd1000 + $signed(64'($urandom_range(0, 12)));
		it.quantity = $urandom_range(1, 50);
		it.top_of_book = $urandom_range(0, 11) == 0;
		it.level_index = $urandom_range(0, 19) == 0 ? 4'($urandom) :
			4'($urandom_range(0, 4));
		pick = $urandom_range(0, 99);
		if (pick < 45) it.kind = mbo_pkg::KIND_ADD;
		else if (pick < 75) it.kind = mbo_pkg::KIND_CANCEL;
		else if (pick < 92) it.kind = mbo_pkg::KIND_MODIFY;
		else if (pick < 98) it.kind = 3'($urandom_range(5, 7)) & 3'h7;
		else it.kind = mbo_pkg::KIND_CLEAR;
		if (pick >= 92 && pick < 95) it.kind = mbo_pkg::KIND_IGNORE;
		if ($urandom_range(0, 15) == 0) begin
			it.ord_key = {$urandom, $urandom};
			it.price = {$urandom, $urandom};
			it.quantity = $urandom;
		end
		if (it.kind == mbo_pkg::KIND_ADD && !it.top_of_book) live_ids.push_back(it.ord_key);
		if (live_ids.size() > 40) void'(live_ids.pop_front());
		return it;
	endfunction

	initial begin
		book = new();
		book.clear_book();
		cycles = 0;
		no_gaps = 0;
		start = 0;
		item = '0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: every kind, extremes, each error except a full book, and special cases
		send_message(make_msg(mbo_pkg::KIND_IGNORE, 2'd2, '1, mbo_pkg::PX_UNDEF, '1, 1, 4'd15));
		send_message(make_msg(mbo_pkg::KIND_ADD, 2'd0, 64'd1, -64'sd5, 32'd10, 0, 4'd0));
		send_message(make_msg(mbo_pkg::KIND_ADD, 2'd0, 64'd2, 64'sd7, '1, 0, 4'd1));
		send_message(make_msg(mbo_pkg::KIND_ADD, 2'd0, 64'd3, 64'sd7, '1, 0, 4'd0));
		send_message(make_msg(mbo_pkg::KIND_ADD, 2'd0, 64'd1, 64'sd9, 32'd1, 0, 4'd0));
		send_message(make_msg(mbo_pkg::KIND_ADD, 2'd1, '1, {1'b1, 63'd0}, 32'd4, 0, 4'd0));
		send_message(make_msg(mbo_pkg::KIND_ADD, 2'd1, 64'd8, 64'sd20, 32'd4, 0, 4'd1));
		send_message(make_msg(mbo_pkg::KIND_ADD, 2'd3, 64'd9, 64'sd20, 32'd4, 0, 4'd0));
		send_message(make_msg(mbo_pkg::KIND_CANCEL, 2'd0, 64'd1, 64'sd99, 32'd1, 0, 4'd0));
		send_message(make_msg(mbo_pkg::KIND_CANCEL, 2'd0, 64'd9, -64'sd5, 32'd1, 0, 4'd0));
		send_message(make_msg(mbo_pkg::KIND_CANCEL, 2'd0, 64'd1, -64'sd5, 32'd11, 0, 4'd0));
		send_message(make_msg(mbo_pkg::KIND_CANCEL, 2'd0, 64'd1, -64'sd5, 32'd10, 0, 4'd0));
		send_message(make_msg(mbo_pkg::KIND_MODIFY, 2'd1, 64'd2, 64'sd7, 32'd3, 0, 4'd0));
		send_message(make_msg(mbo_pkg::KIND_MODIFY, 2'd0, 64'd2, 64'sd6, 32'd3, 0, 4'd1));
		send_message(make_msg(mbo_pkg::KIND_MODIFY, 2'd1, 64'd30, 64'sd25, 32'd2, 0, 4'd1));
		send_message(make_msg(mbo_pkg::KIND_MODIFY, 2'd2, 64'd30, 64'sd25, 32'd2, 0, 4'd0));
		send_message(make_msg(mbo_pkg::KIND_ADD, 2'd1, 64'd8, 64'sd22, 32'd6, 1, 4'd0));
		send_message(make_msg(mbo_pkg::KIND_ADD, 2'd1, 64'd8, 64'sd22, 32'd5, 0, 4'd0));
		send_message(make_msg(mbo_pkg::KIND_CANCEL, 2'd1, 64'd8, 64'sd22, 32'd6, 0, 4'd0));
		send_message(make_msg(mbo_pkg::KIND_ADD, 2'd0, 64'd0, mbo_pkg::PX_UNDEF, 32'd0, 1,
			4'd0));
		send_message(make_msg(mbo_pkg::KIND_ADD, 2'd0, 64'd5, 64'sd3, 32'd1, 0, 4'd15));
		send_message(make_msg(mbo_pkg::KIND_CLEAR, 2'd0, 64'd0, 64'sd0, 32'd0, 0, 4'd0));
		send_message(make_msg(3'd7, 2'd1, 64'd0, 64'sd0, 32'd0, 0, 4'd0));
		start <= 1'b0;

		// let the queue drain once before random traffic
		while (book.pending_books.size() > 0) @(negedge clk);

		for (int n = 0; n < 270; n++) begin
			if (n == 230) no_gaps = 1;
			send_message(random_msg());
		end
		start <= 1'b0;

		while (book.pending_books.size() > 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (book.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
